// ----- design/odometry_pose_predictor_top_macros.svh -----
// assertion macros for the odometry pose predictor
// used by the reduction cell, fold and rotation modules; expects clk and rst_n in scope
`ifndef ODOMETRY_POSE_PREDICTOR_TOP_MACROS_SVH
`define ODOMETRY_POSE_PREDICTOR_TOP_MACROS_SVH

// same-cycle implication
`define OPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/opp_pkg.sv -----
// types and constants shared by the odometry pose predictor
// no dependencies
`timescale 1ns / 1ps

package opp_pkg;

  localparam int POS_W    = 32;
  localparam int HEAD_W   = 21;
  localparam int HDIFF_W  = 22;
  localparam int HSUM_W   = 23;
  localparam int DIFF_W   = 33;
  localparam int MAG_W    = 43;
  localparam int ANG_W    = 34;
  localparam int PROD_W   = 67;
  localparam int ACC_W    = 68;
  localparam int ROT_W    = 36;
  localparam int PSUM_W   = 37;
  localparam int Q_SHIFT  = 30;
  localparam int ATAN_N   = 32;

  localparam logic [MAG_W-1:0] TWO_PI_MAG = 43'd6746518853;

  localparam logic signed [ANG_W-1:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 34'sd6746518853;
  localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] Q30_FOLD_HI = 34'sd5059889140;
  localparam logic signed [ANG_W-1:0] Q30_GAIN    = 34'sd652032874;

  localparam logic signed [ACC_W-1:0] ROUND_Q30 = 68'sd536870912;

  localparam logic signed [POS_W-1:0]  POS_MAX  = 32'sh7fffffff;
  localparam logic signed [POS_W-1:0]  POS_MIN  = 32'sh80000000;
  localparam logic signed [HEAD_W-1:0] HEAD_MAX = 21'sh0fffff;
  localparam logic signed [HEAD_W-1:0] HEAD_MIN = 21'sh100000;

  localparam logic signed [ANG_W-1:0] ATAN_Q30 [ATAN_N] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128,
    34'sd64,        34'sd32,        34'sd16,        34'sd8,
    34'sd4,         34'sd2,         34'sd1,         34'sd0
  };

  typedef struct packed {
    logic signed [POS_W-1:0]  ppx;
    logic signed [POS_W-1:0]  ppy;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [HEAD_W-1:0] head;
    logic                     head_sat;
  } carry_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    carry_t           carry;
  } red_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic                    flip;
    carry_t                  carry;
  } cordic_t;

endpackage

// ----- design/opp_red_cell.sv -----
// one angle reduction cell: conditional subtract of 2*pi scaled by 2^STEP
// depends on opp_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "odometry_pose_predictor_top_macros.svh"

module opp_red_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  opp_pkg::red_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output opp_pkg::red_t dn_data
);

  localparam logic [opp_pkg::MAG_W-1:0] SUB = opp_pkg::TWO_PI_MAG << STEP;

  logic          v_r;
  logic          v_nxt;
  opp_pkg::red_t data_r;
  opp_pkg::red_t data_nxt;

  assign up_ready = !v_r || dn_ready;
  assign v_nxt    = up_ready ? up_valid : v_r;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt = up_data;
    if (up_data.mag >= SUB) begin
      data_nxt.mag = up_data.mag - SUB;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

  `OPP_ASSERT_NOW(a_red_range, v_r, data_r.mag < SUB, "reduced angle above cell bound")

endmodule

// ----- design/opp_fold.sv -----
// quadrant fold: reduced magnitude to signed cordic angle in [-pi/2, pi/2]
// depends on opp_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "odometry_pose_predictor_top_macros.svh"

module opp_fold (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  opp_pkg::red_t    up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output opp_pkg::cordic_t dn_data
);

  logic                            v_r;
  logic                            v_nxt;
  opp_pkg::cordic_t                data_r;
  opp_pkg::cordic_t                data_nxt;
  logic signed [opp_pkg::ANG_W-1:0] ms;
  logic signed [opp_pkg::ANG_W-1:0] t_mid;
  logic signed [opp_pkg::ANG_W-1:0] t_hi;
  logic signed [opp_pkg::ANG_W-1:0] t;
  logic                            hi;
  logic                            mid;

  assign up_ready = !v_r || dn_ready;
  assign v_nxt    = up_ready ? up_valid : v_r;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  assign ms    = signed'(up_data.mag[opp_pkg::ANG_W-1:0]);
  assign t_mid = ms - opp_pkg::Q30_PI;
  assign t_hi  = ms - opp_pkg::Q30_TWO_PI;
  assign hi    = ms >= opp_pkg::Q30_FOLD_HI;
  assign mid   = (ms > opp_pkg::Q30_HALF_PI) && !hi;
  assign t     = hi ? t_hi : (mid ? t_mid : ms);

  always_comb begin
    data_nxt.x     = opp_pkg::Q30_GAIN;
    data_nxt.y     = '0;
    data_nxt.z     = up_data.neg ? -t : t;
    data_nxt.flip  = mid;
    data_nxt.carry = up_data.carry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

  `OPP_ASSERT_NOW(a_fold_range, v_r, (data_r.z <= opp_pkg::Q30_HALF_PI) && (data_r.z >= -opp_pkg::Q30_HALF_PI), "folded angle outside half pi")

endmodule

// ----- design/opp_cordic_cell.sv -----
// one rotation-mode cordic cell with fixed shift and arctangent
// depends on opp_pkg
`timescale 1ns / 1ps

module opp_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  opp_pkg::cordic_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output opp_pkg::cordic_t dn_data
);

  localparam logic signed [opp_pkg::ANG_W-1:0] ATAN = opp_pkg::ATAN_Q30[STAGE];

  logic                             v_r;
  logic                             v_nxt;
  opp_pkg::cordic_t                 data_r;
  opp_pkg::cordic_t                 data_nxt;
  logic signed [opp_pkg::ANG_W-1:0] xs;
  logic signed [opp_pkg::ANG_W-1:0] ys;

  assign up_ready = !v_r || dn_ready;
  assign v_nxt    = up_ready ? up_valid : v_r;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  assign xs = up_data.x >>> STAGE;
  assign ys = up_data.y >>> STAGE;

  always_comb begin
    data_nxt = up_data;
    if (!up_data.z[opp_pkg::ANG_W-1]) begin
      data_nxt.x = up_data.x - ys;
      data_nxt.y = up_data.y + xs;
      data_nxt.z = up_data.z - ATAN;
    end else begin
      data_nxt.x = up_data.x + ys;
      data_nxt.y = up_data.y - xs;
      data_nxt.z = up_data.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- design/opp_rotate.sv -----
// displacement rotation, rounding, final add and saturation, output register
// depends on opp_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "odometry_pose_predictor_top_macros.svh"

module opp_rotate (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  opp_pkg::cordic_t                    up_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [opp_pkg::POS_W-1:0]    out_pred_x,
  output logic signed [opp_pkg::POS_W-1:0]    out_pred_y,
  output logic signed [opp_pkg::HEAD_W-1:0]   out_pred_heading,
  output logic                                out_saturated
);

  // stage a: quadrant sign
  logic                              a_v_r, a_v_nxt, a_rdy;
  logic signed [opp_pkg::ANG_W-1:0]  c_r, c_nxt, s_r, s_nxt;
  opp_pkg::carry_t                   carry_a_r;
  // stage b: products
  logic                              b_v_r, b_v_nxt, b_rdy;
  logic signed [opp_pkg::PROD_W-1:0] pcx_r, pcx_nxt, psy_r, psy_nxt;
  logic signed [opp_pkg::PROD_W-1:0] psx_r, psx_nxt, pcy_r, pcy_nxt;
  opp_pkg::carry_t                   carry_b_r;
  // stage c: sums and rounding
  logic                              c_v_r, c_v_nxt, c_rdy;
  logic signed [opp_pkg::ACC_W-1:0]  accx, accy;
  logic signed [opp_pkg::ROT_W-1:0]  rx_r, rx_nxt, ry_r, ry_nxt;
  opp_pkg::carry_t                   carry_c_r;
  // stage d: output register
  logic                              d_v_r, d_v_nxt, d_rdy;
  logic signed [opp_pkg::PSUM_W-1:0] sumx, sumy;
  logic                              x_ovf, y_ovf;
  logic signed [opp_pkg::POS_W-1:0]  px_r, px_nxt, py_r, py_nxt;
  logic signed [opp_pkg::HEAD_W-1:0] ph_r;
  logic                              x_sat_r, y_sat_r, h_sat_r;
  logic                              x_at_bound;

  assign d_rdy    = !d_v_r || out_ready;
  assign c_rdy    = !c_v_r || d_rdy;
  assign b_rdy    = !b_v_r || c_rdy;
  assign a_rdy    = !a_v_r || b_rdy;
  assign up_ready = a_rdy;

  assign a_v_nxt = a_rdy ? up_valid : a_v_r;
  assign b_v_nxt = b_rdy ? a_v_r : b_v_r;
  assign c_v_nxt = c_rdy ? b_v_r : c_v_r;
  assign d_v_nxt = d_rdy ? c_v_r : d_v_r;

  assign c_nxt = up_data.flip ? -up_data.x : up_data.x;
  assign s_nxt = up_data.flip ? -up_data.y : up_data.y;

  assign pcx_nxt = opp_pkg::PROD_W'(c_r) * opp_pkg::PROD_W'(carry_a_r.dx);
  assign psy_nxt = opp_pkg::PROD_W'(s_r) * opp_pkg::PROD_W'(carry_a_r.dy);
  assign psx_nxt = opp_pkg::PROD_W'(s_r) * opp_pkg::PROD_W'(carry_a_r.dx);
  assign pcy_nxt = opp_pkg::PROD_W'(c_r) * opp_pkg::PROD_W'(carry_a_r.dy);

  assign accx   = opp_pkg::ACC_W'(pcx_r) - opp_pkg::ACC_W'(psy_r) + opp_pkg::ROUND_Q30;
  assign accy   = opp_pkg::ACC_W'(psx_r) + opp_pkg::ACC_W'(pcy_r) + opp_pkg::ROUND_Q30;
  assign rx_nxt = signed'(accx[opp_pkg::Q_SHIFT +: opp_pkg::ROT_W]);
  assign ry_nxt = signed'(accy[opp_pkg::Q_SHIFT +: opp_pkg::ROT_W]);

  assign sumx  = opp_pkg::PSUM_W'(carry_c_r.ppx) + opp_pkg::PSUM_W'(rx_r);
  assign sumy  = opp_pkg::PSUM_W'(carry_c_r.ppy) + opp_pkg::PSUM_W'(ry_r);
  assign x_ovf = sumx[opp_pkg::PSUM_W-1:opp_pkg::POS_W-1]
                 != {(opp_pkg::PSUM_W-opp_pkg::POS_W+1){sumx[opp_pkg::PSUM_W-1]}};
  assign y_ovf = sumy[opp_pkg::PSUM_W-1:opp_pkg::POS_W-1]
                 != {(opp_pkg::PSUM_W-opp_pkg::POS_W+1){sumy[opp_pkg::PSUM_W-1]}};
  assign px_nxt = x_ovf ? (sumx[opp_pkg::PSUM_W-1] ? opp_pkg::POS_MIN : opp_pkg::POS_MAX)
                        : sumx[opp_pkg::POS_W-1:0];
  assign py_nxt = y_ovf ? (sumy[opp_pkg::PSUM_W-1] ? opp_pkg::POS_MIN : opp_pkg::POS_MAX)
                        : sumy[opp_pkg::POS_W-1:0];

  assign out_valid        = d_v_r;
  assign out_pred_x       = px_r;
  assign out_pred_y       = py_r;
  assign out_pred_heading = ph_r;
  assign out_saturated    = x_sat_r || y_sat_r || h_sat_r;

  assign x_at_bound = (px_r == opp_pkg::POS_MAX) || (px_r == opp_pkg::POS_MIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
      c_v_r <= c_v_nxt;
      d_v_r <= d_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      c_r       <= c_nxt;
      s_r       <= s_nxt;
      carry_a_r <= up_data.carry;
    end
    if (b_rdy) begin
      pcx_r     <= pcx_nxt;
      psy_r     <= psy_nxt;
      psx_r     <= psx_nxt;
      pcy_r     <= pcy_nxt;
      carry_b_r <= carry_a_r;
    end
    if (c_rdy) begin
      rx_r      <= rx_nxt;
      ry_r      <= ry_nxt;
      carry_c_r <= carry_b_r;
    end
    if (d_rdy) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      ph_r    <= carry_c_r.head;
      x_sat_r <= x_ovf;
      y_sat_r <= y_ovf;
      h_sat_r <= carry_c_r.head_sat;
    end
  end

  `OPP_ASSERT_NOW(a_x_clamp, out_valid && x_sat_r, x_at_bound, "x flagged but not at a bound")
  `OPP_ASSERT_NEXT(a_b_load, a_v_r && b_rdy, b_v_r, "product stage lost a transaction")

endmodule

// ----- design/odometry_pose_predictor_top.sv -----
// odometry pose predictor top level: entry arithmetic and the cell chain
// depends on opp_pkg, opp_red_cell, opp_fold, opp_cordic_cell, opp_rotate
`timescale 1ns / 1ps

// usage
// - input channel in_*: one transaction carries the last corrected pose, the
//   previous odometry pose and the current odometry pose
// - output channel out_*: one transaction per input, predicted x, y, heading
//   and a saturated flag when any output hit its range limit
// - both channels are valid/ready; a transaction is taken when both are high
// - chain: RED_STEPS reduction cells, where RED_STEPS = 19 - FRAC_BITS
//   (1 when FRAC_BITS >= 18), then the fold, cordic and rotation stages
// - throughput: one transaction per cycle while the receiver does not stall;
//   every reduction, fold, cordic and rotation stage is a registered cell
//   with its own valid bit
// - when the receiver stalls, cells keep filling until the chain is full,
//   then in_ready drops; nothing is lost or repeated
// - synchronous reset clears all valid bits; the chain is empty afterwards

module odometry_pose_predictor_top #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [opp_pkg::POS_W-1:0]  in_prev_pose_x,
  input  logic signed [opp_pkg::POS_W-1:0]  in_prev_pose_y,
  input  logic signed [opp_pkg::HEAD_W-1:0] in_prev_pose_heading,
  input  logic signed [opp_pkg::POS_W-1:0]  in_prev_odom_x,
  input  logic signed [opp_pkg::POS_W-1:0]  in_prev_odom_y,
  input  logic signed [opp_pkg::HEAD_W-1:0] in_prev_odom_heading,
  input  logic signed [opp_pkg::POS_W-1:0]  in_now_odom_x,
  input  logic signed [opp_pkg::POS_W-1:0]  in_now_odom_y,
  input  logic signed [opp_pkg::HEAD_W-1:0] in_now_odom_heading,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [opp_pkg::POS_W-1:0]  out_pred_x,
  output logic signed [opp_pkg::POS_W-1:0]  out_pred_y,
  output logic signed [opp_pkg::HEAD_W-1:0] out_pred_heading,
  output logic                              out_saturated
);

  localparam int ANG_SHIFT = 30 - FRAC_BITS;
  localparam int RED_STEPS = (FRAC_BITS >= 18) ? 1 : 19 - FRAC_BITS;

  logic signed [opp_pkg::HDIFF_W-1:0] d;
  logic        [opp_pkg::HEAD_W-1:0]  abs_d;
  logic signed [opp_pkg::HSUM_W-1:0]  hsum;
  logic                               h_ovf;
  opp_pkg::red_t                      entry;

  opp_pkg::red_t    red_d [RED_STEPS+1];
  logic             red_v [RED_STEPS+1];
  logic             red_rdy [RED_STEPS+1];
  opp_pkg::cordic_t cor_d [CORDIC_STAGES+1];
  logic             cor_v [CORDIC_STAGES+1];
  logic             cor_rdy [CORDIC_STAGES+1];

  // heading offset and predicted heading
  assign d     = opp_pkg::HDIFF_W'(in_prev_pose_heading) - opp_pkg::HDIFF_W'(in_prev_odom_heading);
  assign abs_d = d[opp_pkg::HDIFF_W-1] ? opp_pkg::HEAD_W'(-d) : d[opp_pkg::HEAD_W-1:0];
  assign hsum  = opp_pkg::HSUM_W'(d) + opp_pkg::HSUM_W'(in_now_odom_heading);
  assign h_ovf = hsum[opp_pkg::HSUM_W-1:opp_pkg::HEAD_W-1]
                 != {(opp_pkg::HSUM_W-opp_pkg::HEAD_W+1){hsum[opp_pkg::HSUM_W-1]}};

  always_comb begin
    entry.mag            = opp_pkg::MAG_W'(abs_d) << ANG_SHIFT;
    entry.neg            = d[opp_pkg::HDIFF_W-1];
    entry.carry.ppx      = in_prev_pose_x;
    entry.carry.ppy      = in_prev_pose_y;
    entry.carry.dx       = opp_pkg::DIFF_W'(in_now_odom_x) - opp_pkg::DIFF_W'(in_prev_odom_x);
    entry.carry.dy       = opp_pkg::DIFF_W'(in_now_odom_y) - opp_pkg::DIFF_W'(in_prev_odom_y);
    entry.carry.head     = h_ovf ? (hsum[opp_pkg::HSUM_W-1] ? opp_pkg::HEAD_MIN : opp_pkg::HEAD_MAX)
                                 : hsum[opp_pkg::HEAD_W-1:0];
    entry.carry.head_sat = h_ovf;
  end

  assign red_d[0] = entry;
  assign red_v[0] = in_valid;
  assign in_ready = red_rdy[0];

  for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
    opp_red_cell #(
      .STEP(RED_STEPS - 1 - j)
    ) u_red (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (red_v[j]),
      .up_ready (red_rdy[j]),
      .up_data  (red_d[j]),
      .dn_valid (red_v[j+1]),
      .dn_ready (red_rdy[j+1]),
      .dn_data  (red_d[j+1])
    );
  end

  opp_fold u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (red_v[RED_STEPS]),
    .up_ready (red_rdy[RED_STEPS]),
    .up_data  (red_d[RED_STEPS]),
    .dn_valid (cor_v[0]),
    .dn_ready (cor_rdy[0]),
    .dn_data  (cor_d[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    opp_cordic_cell #(
      .STAGE(i)
    ) u_cordic (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cor_v[i]),
      .up_ready (cor_rdy[i]),
      .up_data  (cor_d[i]),
      .dn_valid (cor_v[i+1]),
      .dn_ready (cor_rdy[i+1]),
      .dn_data  (cor_d[i+1])
    );
  end

  opp_rotate u_rotate (
    .clk              (clk),
    .rst_n            (rst_n),
    .up_valid         (cor_v[CORDIC_STAGES]),
    .up_ready         (cor_rdy[CORDIC_STAGES]),
    .up_data          (cor_d[CORDIC_STAGES]),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pred_x       (out_pred_x),
    .out_pred_y       (out_pred_y),
    .out_pred_heading (out_pred_heading),
    .out_saturated    (out_saturated)
  );

endmodule
